FILE: sv/pdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdc_pkg;

	localparam int FRAME_PIXELS_DEF = 65536;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_SRC_FMT = 3'd0;
	localparam logic [2:0] REG_TGT_FMT = 3'd1;
	localparam logic [2:0] REG_MODE    = 3'd2;
	localparam logic [2:0] REG_GALPHA  = 3'd3;
	localparam logic [2:0] REG_PITCH   = 3'd4;

	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_BLEND = 2'd1;

	localparam logic [2:0] FMT_ARGB = 3'd0;
	localparam logic [2:0] FMT_RGB  = 3'd1;
	localparam logic [2:0] FMT_RGBA = 3'd2;
	localparam logic [2:0] FMT_ABGR = 3'd3;
	localparam logic [2:0] FMT_BGR  = 3'd4;

	localparam logic [3:0] MODE_CLEAR    = 4'd0;
	localparam logic [3:0] MODE_SRC      = 4'd1;
	localparam logic [3:0] MODE_DST      = 4'd2;
	localparam logic [3:0] MODE_SRC_OVER = 4'd3;
	localparam logic [3:0] MODE_DST_OVER = 4'd4;
	localparam logic [3:0] MODE_SRC_IN   = 4'd5;
	localparam logic [3:0] MODE_DST_IN   = 4'd6;
	localparam logic [3:0] MODE_SRC_OUT  = 4'd7;
	localparam logic [3:0] MODE_DST_OUT  = 4'd8;
	localparam logic [3:0] MODE_SRC_ATOP = 4'd9;
	localparam logic [3:0] MODE_DST_ATOP = 4'd10;
	localparam logic [3:0] MODE_XOR      = 4'd11;

	// channels: [0] red, [1] green, [2] blue, [3] alpha
	typedef logic [3:0][7:0] chan4_t;

	// round(a*b/255); t/255 for t < 65536 is (t + (t >> 8) + 1) >> 8
	function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
		logic [16:0] t;
		logic [16:0] q;
		t = 17'(a) * 17'(b) + 17'd127;
		q = t + 17'(t[16:8]) + 17'd1;
		return q[15:8];
	endfunction

	function automatic logic [7:0] sat8(input logic [16:0] v);
		return (v > 17'd255) ? 8'hFF : v[7:0];
	endfunction

	function automatic chan4_t unpack(input logic [2:0] fmt, input logic [31:0] p);
		chan4_t c;
		case (fmt)
			FMT_RGB: begin
				c = {8'hFF, p[7:0], p[15:8], p[23:16]};
			end
			FMT_RGBA: begin
				c = {p[7:0], p[15:8], p[23:16], p[31:24]};
			end
			FMT_ABGR: begin
				c = {p[31:24], p[23:16], p[15:8], p[7:0]};
			end
			FMT_BGR: begin
				c = {8'hFF, p[23:16], p[15:8], p[7:0]};
			end
			default: begin
				c = {p[31:24], p[7:0], p[15:8], p[23:16]};
			end
		endcase
		return c;
	endfunction

	function automatic logic [31:0] pack(input logic [2:0] fmt, input chan4_t c);
		logic [31:0] p;
		case (fmt)
			FMT_RGB:  p = {8'h00, c[0], c[1], c[2]};
			FMT_RGBA: p = {c[0], c[1], c[2], c[3]};
			FMT_ABGR: p = {c[3], c[2], c[1], c[0]};
			FMT_BGR:  p = {8'h00, c[2], c[1], c[0]};
			default:  p = {c[3], c[0], c[1], c[2]};
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: sv/porter_duff_pixel_compositor.sv
// Porter-Duff pixel compositor over a 32-bit framebuffer held in one
// synchronous RAM of FRAME_PIXELS words.
// Input stream (s_*): s_tuser carries the operation (store raw, blend, read),
// s_tdata the column, the row and the source word. Output stream (m_*): one
// transaction per input transaction with the written-flag, the out-of-range
// flag, the pixel index and the written or read word.
// Configuration goes through the APB port: formats, blend mode, global alpha,
// row pitch. Write it only while the block is idle.
// Out-of-range items, stores and skipped blends do not wait for the framebuffer read; a
// read waits for the RAM read turnaround, a blend adds the Porter-Duff stage
// and a blend with divide also runs the rounded un-premultiply divider (17
// restoring steps). One item is in flight at a time; the next is accepted
// in the cycle after the result has moved into the output register, even
// while that waits.
// A stalled receiver holds the result; the block then waits before its
// framebuffer write until the output register frees up.
// Reset clears the control state and the configuration registers to their defaults; the
// framebuffer RAM keeps no reset value and reads undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module porter_duff_pixel_compositor #(
	parameter int FRAME_PIXELS = pdc_pkg::FRAME_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [11:0] pos_x, [23:12] pos_y, [55:24] pixel_in
	input  wire logic [55:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] wrote, [1] out_of_range, [17:2] pixel_addr, [49:18] pixel_out, rest zero
	output logic [55:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int ADDR_W = $clog2(FRAME_PIXELS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MULT = 4'd1;
	localparam logic [3:0] ST_ADDR = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_RDW  = 4'd4;
	localparam logic [3:0] ST_P2   = 4'd5;
	localparam logic [3:0] ST_DLD  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_PACK = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	// how the color of a blend is formed
	localparam logic [1:0] K_DIV  = 2'd0;
	localparam logic [1:0] K_SAT  = 2'd1;
	localparam logic [1:0] K_PICK = 2'd2;
	localparam logic [1:0] K_COPY = 2'd3;

	localparam logic [4:0] DIV_STEPS = 5'd17;

	logic [3:0]  state_q;
	logic [2:0]  src_fmt_q;
	logic [2:0]  tgt_fmt_q;
	logic [3:0]  mode_q;
	logic [7:0]  galpha_q;
	logic [16:0] pitch_q;
	logic        out_valid_q;
	logic [4:0]  cnt_q;

	// item and datapath registers
	logic [1:0]  op_q;
	logic [11:0] x_q;
	logic [11:0] y_q;
	logic [31:0] pix_q;
	logic [28:0] prod_q;
	logic        oor_q;
	logic [15:0] pa_q;
	logic [ADDR_W-1:0] mem_addr_q;
	pdc_pkg::chan4_t s_q;
	pdc_pkg::chan4_t d_q;
	pdc_pkg::chan4_t ps_q;
	pdc_pkg::chan4_t pd_q;
	logic [7:0]  a_sd_q;
	logic [7:0]  a_snd_q;
	logic [7:0]  a_dns_q;
	logic [2:0][8:0]  sum_q;
	logic [7:0]  oa_q;
	logic        div_q;
	pdc_pkg::chan4_t col_q;
	logic [2:0][16:0] num_q;
	logic [2:0][7:0]  rem_q;
	logic [31:0] res_q;
	logic        wr_q;
	logic [31:0] rdata_q;

	logic        out_wrote_q;
	logic        out_oor_q;
	logic [15:0] out_addr_q;
	logic [31:0] out_pix_q;

	logic [31:0] mem [FRAME_PIXELS];

	logic        out_free;
	logic        cfg_we;
	logic        skip;
	logic        mem_we;
	logic        mem_re;
	logic [29:0] addr_full;
	pdc_pkg::chan4_t src_un;
	pdc_pkg::chan4_t dst_un;

	// blend mode decode
	logic [7:0]  f1;
	logic [7:0]  f2;
	pdc_pkg::chan4_t u;
	pdc_pkg::chan4_t v;
	pdc_pkg::chan4_t xs;
	logic [7:0]  oa_n;
	logic [1:0]  kind;
	logic [2:0][8:0] sum_n;
	logic        p2_div;

	logic [2:0][16:0] num_n;
	logic [2:0][7:0]  rem_n;
	pdc_pkg::chan4_t col_fin;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_pix_q, out_addr_q, out_oor_q, out_wrote_q};
	assign pready   = 1'b1;
	assign cfg_we   = psel & penable & pwrite;

	assign out_free  = !out_valid_q || m_tready;
	assign addr_full = 30'(prod_q) + 30'(x_q);
	assign src_un    = pdc_pkg::unpack(src_fmt_q, pix_q);
	assign dst_un    = pdc_pkg::unpack(tgt_fmt_q, rdata_q);
	// transparent source drops the blend, except in clear mode
	assign skip      = (op_q == pdc_pkg::OP_BLEND) && (s_q[3] == 8'd0) &&
	                   (mode_q != pdc_pkg::MODE_CLEAR);
	assign mem_we    = (state_q == ST_DONE) && out_free && wr_q;
	assign mem_re    = (state_q == ST_RD);

	always_comb begin
		case (paddr[4:2])
			pdc_pkg::REG_SRC_FMT: prdata = {29'd0, src_fmt_q};
			pdc_pkg::REG_TGT_FMT: prdata = {29'd0, tgt_fmt_q};
			pdc_pkg::REG_MODE:    prdata = {28'd0, mode_q};
			pdc_pkg::REG_GALPHA:  prdata = {24'd0, galpha_q};
			pdc_pkg::REG_PITCH:   prdata = {15'd0, pitch_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Porter-Duff terms: color = f1*u + f2*v (premultiplied), result alpha oa_n
	always_comb begin
		f1   = 8'hFF;
		f2   = 8'hFF - s_q[3];
		u    = ps_q;
		v    = pd_q;
		xs   = s_q;
		oa_n = pdc_pkg::sat8(17'(s_q[3]) + 17'(a_dns_q));
		kind = K_DIV;
		case (mode_q)
			pdc_pkg::MODE_CLEAR: begin
				oa_n = 8'd0;
				kind = K_PICK;
			end
			pdc_pkg::MODE_SRC: begin
				oa_n = s_q[3];
				kind = K_COPY;
			end
			pdc_pkg::MODE_DST: begin
				xs   = d_q;
				oa_n = d_q[3];
				kind = K_COPY;
			end
			pdc_pkg::MODE_DST_OVER: begin
				u    = pd_q;
				v    = ps_q;
				f2   = 8'hFF - d_q[3];
				oa_n = pdc_pkg::sat8(17'(d_q[3]) + 17'(a_snd_q));
			end
			pdc_pkg::MODE_SRC_IN: begin
				oa_n = a_sd_q;
				kind = K_PICK;
			end
			pdc_pkg::MODE_DST_IN: begin
				xs   = d_q;
				oa_n = a_sd_q;
				kind = K_PICK;
			end
			pdc_pkg::MODE_SRC_OUT: begin
				oa_n = a_snd_q;
				kind = K_PICK;
			end
			pdc_pkg::MODE_DST_OUT: begin
				xs   = d_q;
				oa_n = a_dns_q;
				kind = K_PICK;
			end
			pdc_pkg::MODE_SRC_ATOP: begin
				v    = d_q;
				oa_n = d_q[3];
				kind = K_SAT;
			end
			pdc_pkg::MODE_DST_ATOP: begin
				u    = pd_q;
				v    = s_q;
				f2   = 8'hFF - d_q[3];
				oa_n = s_q[3];
				kind = K_SAT;
			end
			pdc_pkg::MODE_XOR: begin
				f1   = 8'hFF - d_q[3];
				oa_n = pdc_pkg::sat8(17'(a_snd_q) + 17'(a_dns_q));
			end
			default: begin
				kind = K_DIV;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			sum_n[i] = 9'(pdc_pkg::mul8(f1, u[i])) + 9'(pdc_pkg::mul8(f2, v[i]));
		end
		p2_div = (kind == K_DIV) && (oa_n != 8'd0);
	end

	// one restoring step of the un-premultiply divide on all three channels
	always_comb begin
		logic [8:0] t;
		logic       ge;
		for (int i = 0; i < 3; i++) begin
			t        = {rem_q[i], num_q[i][16]};
			ge       = (t >= {1'b0, oa_q});
			rem_n[i] = ge ? 8'(t - {1'b0, oa_q}) : t[7:0];
			num_n[i] = {num_q[i][15:0], ge};
		end
	end

	always_comb begin
		col_fin = col_q;
		if (div_q) begin
			for (int i = 0; i < 3; i++) begin
				col_fin[i] = pdc_pkg::sat8(num_q[i]);
			end
		end
		col_fin[3] = oa_q;
	end

	// framebuffer RAM: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr_q] <= res_q;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr_q];
		end
	end

	// control: sequencer, output valid, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 5'd0;
			src_fmt_q   <= pdc_pkg::FMT_ARGB;
			tgt_fmt_q   <= pdc_pkg::FMT_ARGB;
			mode_q      <= pdc_pkg::MODE_SRC_OVER;
			galpha_q    <= 8'hFF;
			pitch_q     <= 17'd256;
		end else begin
			if (cfg_we) begin
				case (paddr[4:2])
					pdc_pkg::REG_SRC_FMT: src_fmt_q <= pwdata[2:0];
					pdc_pkg::REG_TGT_FMT: tgt_fmt_q <= pwdata[2:0];
					pdc_pkg::REG_MODE:    mode_q    <= pwdata[3:0];
					pdc_pkg::REG_GALPHA:  galpha_q  <= pwdata[7:0];
					pdc_pkg::REG_PITCH:   pitch_q   <= pwdata[16:0];
					default: ;
				endcase
			end

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_RD;
				ST_RD: begin
					// no wait for the framebuffer read for out of range, store or skipped blend
					if (oor_q || (op_q == pdc_pkg::OP_STORE) || skip) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					state_q <= op_q[1] ? ST_DONE : ST_P2;
				end
				ST_P2: begin
					state_q <= p2_div ? ST_DLD : ST_PACK;
				end
				ST_DLD: begin
					state_q <= ST_DIV;
					cnt_q   <= DIV_STEPS;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_PACK;
					end
				end
				ST_PACK: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q  <= s_tuser;
					x_q   <= s_tdata[11:0];
					y_q   <= s_tdata[23:12];
					pix_q <= s_tdata[55:24];
				end
			end
			ST_MULT: begin
				prod_q <= 29'(y_q) * 29'(pitch_q);
			end
			ST_ADDR: begin
				oor_q      <= (addr_full >= 30'(FRAME_PIXELS));
				pa_q       <= (addr_full >= 30'(FRAME_PIXELS)) ? 16'd0 : addr_full[15:0];
				mem_addr_q <= addr_full[ADDR_W-1:0];
				s_q        <= {pdc_pkg::mul8(galpha_q, src_un[3]), src_un[2], src_un[1],
				               src_un[0]};
			end
			ST_RD: begin
				// default answer; read and blend overwrite it later
				res_q <= (!oor_q && (op_q == pdc_pkg::OP_STORE)) ? pix_q : 32'd0;
				wr_q  <= !oor_q && (op_q == pdc_pkg::OP_STORE);
			end
			ST_RDW: begin
				if (op_q[1]) begin
					res_q <= rdata_q;
				end
				d_q <= dst_un;
				for (int i = 0; i < 4; i++) begin
					ps_q[i] <= pdc_pkg::mul8(s_q[3], s_q[i]);
					pd_q[i] <= pdc_pkg::mul8(dst_un[3], dst_un[i]);
				end
				a_sd_q  <= pdc_pkg::mul8(s_q[3], dst_un[3]);
				a_snd_q <= pdc_pkg::mul8(s_q[3], 8'hFF - dst_un[3]);
				a_dns_q <= pdc_pkg::mul8(dst_un[3], 8'hFF - s_q[3]);
			end
			ST_P2: begin
				sum_q <= sum_n;
				oa_q  <= oa_n;
				div_q <= p2_div;
				for (int i = 0; i < 3; i++) begin
					case (kind)
						K_SAT:   col_q[i] <= (oa_n != 8'd0) ? pdc_pkg::sat8(17'(sum_n[i])) : 8'd0;
						K_PICK:  col_q[i] <= (oa_n != 8'd0) ? xs[i] : 8'd0;
						K_COPY:  col_q[i] <= xs[i];
						default: col_q[i] <= 8'd0;
					endcase
				end
				col_q[3] <= oa_n;
			end
			ST_DLD: begin
				// rounded divide: (sum*255 + oa/2) / oa
				for (int i = 0; i < 3; i++) begin
					num_q[i] <= 17'({sum_q[i], 8'h00}) - 17'(sum_q[i]) + 17'(oa_q[7:1]);
					rem_q[i] <= 8'd0;
				end
			end
			ST_DIV: begin
				num_q <= num_n;
				rem_q <= rem_n;
			end
			ST_PACK: begin
				res_q <= pdc_pkg::pack(tgt_fmt_q, col_fin);
				wr_q  <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_wrote_q <= wr_q;
					out_oor_q   <= oor_q;
					out_addr_q  <= pa_q;
					out_pix_q   <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_oor_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (!m_tdata[0] && (m_tdata[17:2] == 16'd0)))
		else $error("out-of-range result carries a write or an address");

	a_no_oor_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !oor_q)
		else $error("framebuffer written for an out-of-range item");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MULT))
		else $error("accepted item did not start address computation");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ((oa_q != 8'd0) && (cnt_q != 5'd0)))
		else $error("divider running with zero divisor or no steps left");
`endif

endmodule
`default_nettype wire

FILE: sim/porter_duff_pixel_compositor_tb.sv
`timescale 1ns / 1ps
module porter_duff_pixel_compositor_tb;

	localparam int FRAME = 65536;
	localparam int LIMIT = 2000000;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_READ_ALT = 2'd3;

	// one result transaction
	typedef struct packed {
		logic        wrote;
		logic        oor;
		logic [15:0] addr;
		logic [31:0] pix;
	} pix_result_t;

	typedef struct {
		logic [1:0]  op;
		logic [11:0] px;
		logic [11:0] py;
		logic [31:0] word;
		logic        fixed;    // expected value typed in below
		pix_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	porter_duff_pixel_compositor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the framebuffer and the register file
	logic [31:0] shadow_fb [FRAME];
	bit          shadow_valid [FRAME];
	logic [2:0]  cfg_src_fmt, cfg_tgt_fmt;
	logic [3:0]  cfg_mode;
	logic [7:0]  cfg_galpha;
	logic [16:0] cfg_pitch;

	pix_result_t expected_q [$];
	int          mismatches;
	int          cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---- predictor -------------------------------------------------------
	function automatic int unsigned rmul(int unsigned a, int unsigned b);
		return (a * b + 127) / 255;
	endfunction

	function automatic int unsigned clamp255(int unsigned v);
		return (v > 255) ? 255 : v;
	endfunction

	function automatic int unsigned divide_out(int unsigned s, int unsigned oa);
		if (oa == 0) return 0;
		return clamp255((s * 255 + oa / 2) / oa);
	endfunction

	// channel order: red, green, blue, alpha
	function automatic void split_pixel(input logic [2:0] fmt, input logic [31:0] p,
			output int unsigned c [4]);
		case (fmt)
			pdc_pkg::FMT_RGB: begin
				c[0] = p[23:16]; c[1] = p[15:8]; c[2] = p[7:0]; c[3] = 255;
			end
			pdc_pkg::FMT_RGBA: begin
				c[0] = p[31:24]; c[1] = p[23:16]; c[2] = p[15:8]; c[3] = p[7:0];
			end
			pdc_pkg::FMT_ABGR: begin
				c[0] = p[7:0]; c[1] = p[15:8]; c[2] = p[23:16]; c[3] = p[31:24];
			end
			pdc_pkg::FMT_BGR: begin
				c[0] = p[7:0]; c[1] = p[15:8]; c[2] = p[23:16]; c[3] = 255;
			end
			default: begin
				c[0] = p[23:16]; c[1] = p[15:8]; c[2] = p[7:0]; c[3] = p[31:24];
			end
		endcase
	endfunction

	function automatic logic [31:0] join_pixel(input logic [2:0] fmt, input int unsigned c [4]);
		logic [7:0] r, g, b, a;
		r = 8'(c[0]); g = 8'(c[1]); b = 8'(c[2]); a = 8'(c[3]);
		case (fmt)
			pdc_pkg::FMT_RGB:  return {8'h00, r, g, b};
			pdc_pkg::FMT_RGBA: return {r, g, b, a};
			pdc_pkg::FMT_ABGR: return {a, b, g, r};
			pdc_pkg::FMT_BGR:  return {8'h00, b, g, r};
			default:           return {a, r, g, b};
		endcase
	endfunction

	function automatic void weigh_sum(input int unsigned x [4], input int unsigned y [4],
			input int unsigned fx, input int unsigned fy, input int unsigned oa,
			output int unsigned o [4]);
		for (int i = 0; i < 3; i++)
			o[i] = divide_out(rmul(fx, rmul(x[3], x[i])) + rmul(fy, rmul(y[3], y[i])), oa);
		o[3] = oa;
	endfunction

	function automatic void keep_one(input int unsigned x [4], input int unsigned oa,
			output int unsigned o [4]);
		for (int i = 0; i < 3; i++) o[i] = oa ? x[i] : 0;
		o[3] = oa;
	endfunction

	function automatic void lay_atop(input int unsigned x [4], input int unsigned y [4],
			input int unsigned oa, output int unsigned o [4]);
		for (int i = 0; i < 3; i++)
			o[i] = oa ? clamp255(rmul(x[3], x[i]) + rmul(255 - x[3], y[i])) : 0;
		o[3] = oa;
	endfunction

	function automatic pix_result_t predict_pixel(logic [1:0] op, logic [11:0] px,
			logic [11:0] py, logic [31:0] word);
		pix_result_t r;
		longint unsigned idx;
		int unsigned s [4], d [4], o [4];
		int unsigned sa, da;
		bit tgt_alpha;
		r = '0;
		idx = longint'(py) * longint'(cfg_pitch) + longint'(px);
		if (idx >= FRAME) begin
			r.oor = 1'b1;
			return r;
		end
		r.addr = idx[15:0];
		case (op)
			pdc_pkg::OP_STORE: begin
				shadow_fb[idx] = word;
				shadow_valid[idx] = 1'b1;
				r.wrote = 1'b1;
				r.pix = word;
			end
			pdc_pkg::OP_BLEND: begin
				split_pixel(cfg_src_fmt, word, s);
				s[3] = rmul(cfg_galpha, s[3]);
				if (s[3] != 0 || cfg_mode == pdc_pkg::MODE_CLEAR) begin
					split_pixel(cfg_tgt_fmt, shadow_fb[idx], d);
					sa = s[3];
					da = d[3];
					case (cfg_mode)
						pdc_pkg::MODE_CLEAR:    o = '{0, 0, 0, 0};
						pdc_pkg::MODE_SRC:      o = s;
						pdc_pkg::MODE_DST:      o = d;
						pdc_pkg::MODE_DST_OVER: weigh_sum(d, s, 255, 255 - da,
								clamp255(da + rmul(255 - da, sa)), o);
						pdc_pkg::MODE_SRC_IN:   keep_one(s, rmul(sa, da), o);
						pdc_pkg::MODE_DST_IN:   keep_one(d, rmul(da, sa), o);
						pdc_pkg::MODE_SRC_OUT:  keep_one(s, rmul(sa, 255 - da), o);
						pdc_pkg::MODE_DST_OUT:  keep_one(d, rmul(da, 255 - sa), o);
						pdc_pkg::MODE_SRC_ATOP: lay_atop(s, d, da, o);
						pdc_pkg::MODE_DST_ATOP: lay_atop(d, s, sa, o);
						pdc_pkg::MODE_XOR:      weigh_sum(s, d, 255 - da, 255 - sa,
								clamp255(rmul(sa, 255 - da) + rmul(da, 255 - sa)), o);
						default:                weigh_sum(s, d, 255, 255 - sa,
								clamp255(sa + rmul(255 - sa, da)), o);
					endcase
					tgt_alpha = !(cfg_tgt_fmt == pdc_pkg::FMT_RGB ||
						cfg_tgt_fmt == pdc_pkg::FMT_BGR);
					if (!tgt_alpha) o[3] = 255;
					r.pix = join_pixel(cfg_tgt_fmt, o);
					shadow_fb[idx] = r.pix;
					r.wrote = 1'b1;
				end
			end
			default: r.pix = shadow_fb[idx];
		endcase
		return r;
	endfunction

	// ---- register writes -------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			pdc_pkg::REG_SRC_FMT: cfg_src_fmt = value[2:0];
			pdc_pkg::REG_TGT_FMT: cfg_tgt_fmt = value[2:0];
			pdc_pkg::REG_MODE:    cfg_mode = value[3:0];
			pdc_pkg::REG_GALPHA:  cfg_galpha = value[7:0];
			pdc_pkg::REG_PITCH:   cfg_pitch = value[16:0];
			default: ;
		endcase
	endtask

	// drop the input valid and wait until every expected result has come
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// wait until the block has drained, then for its longest latency
	task automatic settle();
		drain();
		repeat (40) @(posedge clk);
	endtask

	task automatic set_all(logic [2:0] sf, logic [2:0] tf, logic [3:0] md,
			logic [7:0] ga, logic [16:0] pitch);
		settle();
		write_reg(pdc_pkg::REG_SRC_FMT, 32'(sf));
		write_reg(pdc_pkg::REG_TGT_FMT, 32'(tf));
		write_reg(pdc_pkg::REG_MODE, 32'(md));
		write_reg(pdc_pkg::REG_GALPHA, 32'(ga));
		write_reg(pdc_pkg::REG_PITCH, 32'(pitch));
	endtask

	// ---- input side: one transaction per call --------------------------
	// valid stays high after the accepting edge; the next call replaces the item or drops valid for a gap, drain drops it
	task automatic push_pixel(logic [1:0] op, logic [11:0] px, logic [11:0] py,
			logic [31:0] word);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {word, py, px};
		expected_q.push_back(predict_pixel(op, px, py, word));
		do @(posedge clk); while (!s_tready);
	endtask

	// directed row with a typed-in answer: check it against the predictor too
	task automatic push_row(stim_row_t row);
		pix_result_t pred;
		push_pixel(row.op, row.px, row.py, row.word);
		pred = expected_q[$];
		if (row.fixed && pred != row.res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row mismatch: table %h predicted %h", row.res, pred);
		end
	endtask

	// ---- output side -----------------------------------------------------
	int hold_off;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", m_tdata);
				end else begin
					pix_result_t want, got;
					want = expected_q.pop_front();
					got.wrote = m_tdata[0];
					got.oor = m_tdata[1];
					got.addr = m_tdata[17:2];
					got.pix = m_tdata[49:18];
					if (got !== want || m_tdata[55:50] !== '0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: wrote %b/%b oor %b/%b addr %h/%h pix %h/%h",
								want.wrote, got.wrote, want.oor, got.oor,
								want.addr, got.addr, want.pix, got.pix);
					end
				end
			end
			// draw a fresh stall after each transaction, sometimes none at all
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				if ($urandom_range(0, 3) == 0) m_tready <= 1'b1;
				else begin
					hold_off <= $urandom_range(0, 4);
					m_tready <= 1'b0;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---- random traffic --------------------------------------------------
	// often pick a position known to hold data; most positions stay within the frame
	int written_x [$];
	int written_y [$];

	task automatic random_pixel();
		logic [11:0] px, py;
		logic [1:0] op;
		longint unsigned idx;
		int k;
		int pick_kind;
		pick_kind = $urandom_range(0, 9);
		if (pick_kind == 0) begin
			// random position: usually out of range
			px = 12'($urandom);
			py = 12'($urandom);
		end else if (written_x.size() > 0 && pick_kind > 3) begin
			k = $urandom_range(0, written_x.size() - 1);
			px = 12'(written_x[k]);
			py = 12'(written_y[k]);
		end else begin
			px = 12'($urandom_range(0, 4095));
			py = (cfg_pitch == 0) ? 12'($urandom) : 12'($urandom_range(0, 65535 / cfg_pitch));
		end
		idx = longint'(py) * longint'(cfg_pitch) + longint'(px);
		op = 2'($urandom_range(0, 3));
		// never touch an entry that was never written
		if (idx < FRAME && !shadow_valid[idx]) op = pdc_pkg::OP_STORE;
		if (op == pdc_pkg::OP_STORE && idx < FRAME) begin
			written_x.push_back(px);
			written_y.push_back(py);
		end
		push_pixel(op, px, py, $urandom);
	endtask

	stim_row_t table_rows [$];
	initial begin
		logic [7:0] ga_pick [4];
		ga_pick = '{8'd0, 8'd1, 8'd128, 8'd255};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pdc_pkg::OP_STORE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		mismatches = 0;
		cfg_src_fmt = pdc_pkg::FMT_ARGB;
		cfg_tgt_fmt = pdc_pkg::FMT_ARGB;
		cfg_mode = pdc_pkg::MODE_SRC_OVER;
		cfg_galpha = 8'd255;
		cfg_pitch = 17'd256;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset settings (pitch 256)
		table_rows = '{
			'{pdc_pkg::OP_STORE, 12'd0, 12'd0, 32'h80402010, 1'b1,
				'{1'b1, 1'b0, 16'h0000, 32'h80402010}},
			'{OP_READ, 12'd0, 12'd0, 32'h0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'h80402010}},
			'{pdc_pkg::OP_STORE, 12'd255, 12'd255, 32'hFFFFFFFF, 1'b1,
				'{1'b1, 1'b0, 16'hFFFF, 32'hFFFFFFFF}},
			'{OP_READ_ALT, 12'd255, 12'd255, 32'h0, 1'b1,
				'{1'b0, 1'b0, 16'hFFFF, 32'hFFFFFFFF}},
			'{pdc_pkg::OP_STORE, 12'd4095, 12'd4095, 32'h12345678, 1'b1,
				'{1'b0, 1'b1, 16'h0, 32'h0}},
			'{pdc_pkg::OP_BLEND, 12'd0, 12'd256, 32'h12345678, 1'b1,
				'{1'b0, 1'b1, 16'h0, 32'h0}},
			// transparent source over existing entry: skipped
			'{pdc_pkg::OP_BLEND, 12'd0, 12'd0, 32'h00FFFFFF, 1'b1,
				'{1'b0, 1'b0, 16'h0000, 32'h0}},
			// opaque source over: replaces the entry
			'{pdc_pkg::OP_BLEND, 12'd0, 12'd0, 32'hFF112233, 1'b1,
				'{1'b1, 1'b0, 16'h0000, 32'hFF112233}},
			'{pdc_pkg::OP_STORE, 12'd1, 12'd0, 32'h00000000, 1'b0, '0},
			'{pdc_pkg::OP_BLEND, 12'd1, 12'd0, 32'h80FF0000, 1'b0, '0},
			'{pdc_pkg::OP_BLEND, 12'd255, 12'd255, 32'h7F00FF00, 1'b0, '0}
		};
		foreach (table_rows[i]) push_row(table_rows[i]);

		// every mode and format against a small patch of written pixels
		for (int m = 0; m < 16; m++) begin
			set_all(3'(m % 8), 3'((m * 3) % 8), 4'(m), ga_pick[m % 4], 17'd256);
			for (int j = 0; j < 2; j++) begin
				push_pixel(pdc_pkg::OP_STORE, 12'(10 + j), 12'd3, $urandom);
				push_pixel(pdc_pkg::OP_BLEND, 12'(10 + j), 12'd3,
					(j == 0) ? 32'h00000000 : $urandom);
			end
		end

		// random phases, pitch extremes among them; pause with drain between
		for (int ph = 0; ph < 8; ph++) begin
			logic [16:0] pitch;
			case (ph)
				0: pitch = 17'd0;
				1: pitch = 17'd1;
				2: pitch = 17'd65536;
				3: pitch = 17'h1FFFF;
				default: pitch = 17'($urandom_range(1, 512));
			endcase
			set_all(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)),
				(ph == 4) ? 8'd0 : (($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom)),
				pitch);
			written_x.delete();
			written_y.delete();
			for (int i = 0; i < 90; i++) begin
				random_pixel();
				// hold the sender until every result is in
				if (i == 45) drain();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
